FILE: hw/rtl/iws_pkg.sv
`timescale 1ns / 1ps

package iws_pkg;

  // Line buffer depth and derived widths
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int AW_W      = $clog2(MAX_WIDTH + 1);
  localparam int MIN_WIDTH = 3;

  // Field widths
  localparam int PIX_W  = 8;
  localparam int ROW_W  = 16;
  localparam int OCOL_W = 10;
  localparam int CFG_W  = 11;
  localparam int SUM_W  = PIX_W + 4;

  // Configuration port
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd640;

  typedef enum logic [APB_AW-3:0] {
    REG_IMAGE_WIDTH = 1'b0
  } reg_idx_e;

endpackage

FILE: hw/rtl/iws_if.sv
`timescale 1ns / 1ps

interface iws_in_if;
  import iws_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             start_of_frame;

  modport source (output valid, pixel_in, start_of_frame, input ready);
  modport sink   (input valid, pixel_in, start_of_frame, output ready);
endinterface

interface iws_out_if;
  import iws_pkg::*;
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_out;
  logic [ROW_W-1:0]  out_row;
  logic [OCOL_W-1:0] out_col;

  modport source (output valid, pixel_out, out_row, out_col, input ready);
  modport sink   (input valid, pixel_out, out_row, out_col, output ready);
endinterface

FILE: hw/rtl/iws_line_ram.sv
`timescale 1ns / 1ps

module iws_line_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; a write at the same edge is passed through
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/iws_cell.sv
`timescale 1ns / 1ps

module iws_cell
  import iws_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             heavy_i,
  input  logic [PIX_W-1:0] pix_i,
  input  logic [SUM_W-1:0] acc_i,
  output logic [PIX_W-1:0] pix_o,
  output logic [SUM_W-1:0] acc_o
);

  logic [PIX_W-1:0] pix_q;
  logic [PIX_W-1:0] pix_d;
  logic [SUM_W-1:0] term;

  // Take the neighbor's pixel when the window advances
  assign pix_d = en_i ? pix_i : pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else begin
      pix_q <= pix_d;
    end
  end

  // Add this tap into the running sum, the center at weight eight
  assign term  = heavy_i ? {1'b0, pix_q, 3'b000} : SUM_W'(pix_q);
  assign acc_o = acc_i + term;
  assign pix_o = pix_q;

endmodule

FILE: hw/rtl/inplace_3x3_weighted_smooth_top.sv
// Channel  Dir  Payload                              Handshake
// in_if    in   pixel_in[7:0], start_of_frame        valid/ready
// out_if   out  pixel_out[7:0], out_row[15:0],       valid/ready
//               out_col[9:0]
// apb      in   image_width at address 0             psel/penable, pready=1
//
// One pixel per clock unless input is refused; stage 1 registers a result's
// lower-right pixel, then loads out_if. That rate is set by the loop from the
// left tap through the adder chain of the window cells, and by the one write
// and one read port of each line buffer. Reset clears counters, window and
// handshake state; the line buffers are not cleared. A stalled result holds
// the stage behind it, and input is refused only while both are full.
`timescale 1ns / 1ps

module inplace_3x3_weighted_smooth_top
  import iws_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  iws_in_if.sink            in_if,
  iws_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef struct packed {
    logic             emit;
    logic             wr_up;
    logic             last;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] pix;
  } s1_t;

  // Configuration register
  logic [CFG_W-1:0] cfg_q;
  logic [CFG_W-1:0] cfg_d;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[APB_AW-1:2] == REG_IMAGE_WIDTH);
  assign cfg_d  = cfg_we ? pwdata[CFG_W-1:0] : cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= WIDTH_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr[APB_AW-1:2])
      REG_IMAGE_WIDTH: prdata = APB_DW'(cfg_q);
      default:         prdata = '0;
    endcase
  end

  // Clamp the width into the supported range
  logic [AW_W-1:0] aw;

  always_comb begin
    if (cfg_q < CFG_W'(MIN_WIDTH)) begin
      aw = AW_W'(MIN_WIDTH);
    end else if (32'(cfg_q) > MAX_WIDTH) begin
      aw = AW_W'(MAX_WIDTH);
    end else begin
      aw = AW_W'(cfg_q);
    end
  end

  // Handshake state
  logic s1_v_q, s1_v_d;
  logic out_v_q, out_v_d;
  logic s1_fire;
  logic in_acc;

  s1_t s1_q, s1_d;

  assign s1_fire     = s1_v_q && (!out_v_q || out_if.ready);
  assign in_if.ready = !s1_v_q || s1_fire;
  assign in_acc      = in_if.valid && in_if.ready;

  // Position of the incoming pixel
  logic [COL_W-1:0] col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d, row_cur;
  logic [AW_W-1:0]  col_ext;
  logic             wrap;

  assign col_cur = in_if.start_of_frame ? '0 : col_q;
  assign row_cur = in_if.start_of_frame ? '0 : row_q;
  assign col_ext = AW_W'(col_cur);
  assign wrap    = ({1'b0, col_ext} + 1'b1) >= {1'b0, aw};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    s1_d  = s1_q;
    if (in_acc) begin
      if (wrap) begin
        col_d = '0;
        row_d = (row_cur != '1) ? row_cur + 1'b1 : row_cur;
      end else begin
        col_d = col_cur + 1'b1;
        row_d = row_cur;
      end
      s1_d.emit  = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2)) && (col_ext < aw);
      s1_d.wr_up = (col_cur != '0);
      s1_d.last  = (col_ext == aw - 1'b1);
      s1_d.col   = col_cur;
      s1_d.row   = row_cur - 1'b1;
      s1_d.pix   = in_if.pixel_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // Line buffers
  logic [PIX_W-1:0] up_rdata, mid_rdata;
  logic             up_we;
  logic [COL_W-1:0] up_waddr;
  logic [PIX_W-1:0] up_wdata;
  logic [PIX_W-1:0] fin;

  logic             pend_q, pend_d;
  logic [COL_W-1:0] pend_addr_q, pend_addr_d;
  logic [PIX_W-1:0] pend_data_q, pend_data_d;
  logic             up_direct;

  // The row's last raw value goes in through the pending register, on a free port slot
  assign up_direct = s1_fire && s1_q.wr_up;
  assign up_we     = up_direct || pend_q;
  assign up_waddr  = up_direct ? s1_q.col - 1'b1 : pend_addr_q;
  assign up_wdata  = up_direct ? fin : pend_data_q;

  always_comb begin
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    pend_data_d = pend_data_q;
    if (s1_fire && s1_q.last) begin
      pend_d      = 1'b1;
      pend_addr_d = s1_q.col;
      pend_data_d = mid_rdata;
    end else if (!up_direct) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    pend_data_q <= pend_data_d;
  end

  iws_line_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (up_we),
    .waddr_i (up_waddr),
    .wdata_i (up_wdata),
    .re_i    (in_acc),
    .raddr_i (col_cur),
    .rdata_o (up_rdata)
  );

  iws_line_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_q.col),
    .wdata_i (s1_q.pix),
    .re_i    (in_acc),
    .raddr_i (col_cur),
    .rdata_o (mid_rdata)
  );

  // Window cells: upper row, left, center, lower row; sum runs through them
  logic [PIX_W-1:0] up_val, ul_val, left_val, ctr_val, low_val, ll_val;
  logic [SUM_W-1:0] seed, acc_up, acc_ul, acc_left, acc_ctr, acc_low, acc_ll;

  assign seed = SUM_W'(up_rdata) + SUM_W'(mid_rdata) + SUM_W'(s1_q.pix);

  iws_cell u_cell_up (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (s1_fire), .heavy_i (1'b0),
    .pix_i (up_rdata), .acc_i (seed), .pix_o (up_val), .acc_o (acc_up)
  );

  iws_cell u_cell_ul (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (s1_fire), .heavy_i (1'b0),
    .pix_i (up_val), .acc_i (acc_up), .pix_o (ul_val), .acc_o (acc_ul)
  );

  iws_cell u_cell_left (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (s1_fire), .heavy_i (1'b0),
    .pix_i (fin), .acc_i (acc_ul), .pix_o (left_val), .acc_o (acc_left)
  );

  iws_cell u_cell_ctr (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (s1_fire), .heavy_i (1'b1),
    .pix_i (mid_rdata), .acc_i (acc_left), .pix_o (ctr_val), .acc_o (acc_ctr)
  );

  iws_cell u_cell_low (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (s1_fire), .heavy_i (1'b0),
    .pix_i (s1_q.pix), .acc_i (acc_ctr), .pix_o (low_val), .acc_o (acc_low)
  );

  iws_cell u_cell_ll (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (s1_fire), .heavy_i (1'b0),
    .pix_i (low_val), .acc_i (acc_low), .pix_o (ll_val), .acc_o (acc_ll)
  );

  // Interior pixels take the smoothed value, border pixels stay raw
  assign fin = s1_q.emit ? acc_ll[SUM_W-1 -: PIX_W] : ctr_val;

  // Output register
  logic [PIX_W-1:0]  out_pix_q, out_pix_d;
  logic [ROW_W-1:0]  out_row_q, out_row_d;
  logic [OCOL_W-1:0] out_col_q, out_col_d;

  always_comb begin
    s1_v_d    = in_acc || (s1_v_q && !s1_fire);
    out_v_d   = (s1_fire && s1_q.emit) || (out_v_q && !out_if.ready);
    out_pix_d = out_pix_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    if (s1_fire && s1_q.emit) begin
      out_pix_d = fin;
      out_row_d = s1_q.row;
      out_col_d = OCOL_W'(s1_q.col - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pix_q <= out_pix_d;
    out_row_q <= out_row_d;
    out_col_q <= out_col_d;
  end

  assign out_if.valid     = out_v_q;
  assign out_if.pixel_out = out_pix_q;
  assign out_if.out_row   = out_row_q;
  assign out_if.out_col   = out_col_q;

`ifndef SYNTHESIS
  // The deferred upper write never collides with a direct one
  a_pend_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pend_q && up_direct))
    else $error("deferred upper-line write collides with direct write");

  // A deferred write is flushed in the following cycle unless another row end fires
  a_pend_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !(s1_fire && s1_q.last)) |=> !pend_q)
    else $error("deferred upper-line write not flushed");

  // An interior item always lands in the output register
  a_emit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_q.emit) |=> out_v_q)
    else $error("smoothed item lost on the way to the output");

  // Input is refused only while both stages are full and the output stalls
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> (s1_v_q && out_v_q && !out_if.ready))
    else $error("input refused without a full pipeline");
`endif

endmodule
